@@ rtl/cmfuv_pkg.sv @@
// Shared constants and types for the cube-map face and coordinate block.
`timescale 1ns / 1ps
package cmfuv_pkg;

  // Fraction bits of a face coordinate, and quotient bits of one divide
  // (the quotient reaches 1.0 exactly, so one bit more).
  localparam int FRAC_BITS  = 16;
  localparam int QUOT_BITS  = FRAC_BITS + 1;

  typedef logic [2:0] face_t;

  localparam face_t FACE_POS_X = 3'd0;
  localparam face_t FACE_NEG_X = 3'd1;
  localparam face_t FACE_POS_Y = 3'd2;
  localparam face_t FACE_NEG_Y = 3'd3;
  localparam face_t FACE_POS_Z = 3'd4;
  localparam face_t FACE_NEG_Z = 3'd5;

  localparam logic [FRAC_BITS-1:0] COORD_MAX = '1;

endpackage

@@ rtl/cube_map_face_and_uv.sv @@
// Path from input word to output word: front register, queue, 17 divider stages,
// output register.
// Throughput: one direction per cycle while the output is not stalled; each of the
// 17 pipeline stages holds one quotient bit of the two coordinate dividers.
// Reset (rst, synchronous, active high) empties the front register, the queue
// and the pipeline valid bits; data registers are not reset.
`timescale 1ns / 1ps
module cube_map_face_and_uv #(
  parameter int COMPONENT_BITS = 16,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic clk,
  input  logic rst,

  // Input stream: one direction vector per word.
  input  logic                                    s_tvalid,
  output logic                                    s_tready,
  // tdata, from bit 0: dir_x, dir_y, dir_z (COMPONENT_BITS each), zero pad
  input  logic [((3*COMPONENT_BITS+7)/8)*8-1:0]   s_tdata,

  // Output stream: face and coordinates.
  output logic                                    m_tvalid,
  input  logic                                    m_tready,
  // tdata, from bit 0: face[2:0], coord_u[15:0], coord_v[15:0], zero pad
  output logic [39:0]                             m_tdata,
  // tuser: degenerate (all components zero)
  output logic                                    m_tuser
);

  localparam int B      = COMPONENT_BITS;
  localparam int QB     = cmfuv_pkg::QUOT_BITS;
  localparam int FB     = cmfuv_pkg::FRAC_BITS;
  localparam int ITEM_W = 4 + (B + 1) + 2 * (B + QB);

  logic              fr_valid;
  logic              fr_ready;
  logic [ITEM_W-1:0] fr_item;
  logic              q_valid;
  logic              q_ready;
  logic [ITEM_W-1:0] q_item;

  cmfuv_pkg::face_t  face;
  logic [FB-1:0]     coord_u;
  logic [FB-1:0]     coord_v;
  logic              degenerate;

  // Front: classify the vector and set up the divider operands
  // (dividend = (m +/- a) * 2^16 + m, divisor = 2m).
  cmfuv_front #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_x      (s_tdata[B-1:0]),
    .in_y      (s_tdata[2*B-1:B]),
    .in_z      (s_tdata[3*B-1:2*B]),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  // Decoupling queue: front keeps accepting while the divider stalls briefly.
  cmfuv_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fr_valid),
    .in_ready  (fr_ready),
    .in_data   (fr_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_item)
  );

  // Back: bit-per-stage dividers, saturation at 1.0, zero-vector override.
  cmfuv_back #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_face  (face),
    .out_u     (coord_u),
    .out_v     (coord_v),
    .out_degen (degenerate)
  );

  assign m_tdata = {5'b0, coord_v, coord_u, face};
  assign m_tuser = degenerate;

endmodule

@@ rtl/cmfuv_front.sv @@
// Front end: major-axis pick, face code and divider operand setup.
`timescale 1ns / 1ps
module cmfuv_front #(
  parameter int COMPONENT_BITS = 16,
  localparam int B      = COMPONENT_BITS,
  localparam int QB     = cmfuv_pkg::QUOT_BITS,
  localparam int ITEM_W = 4 + (B + 1) + 2 * (B + QB)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [B-1:0]      in_x,
  input  logic [B-1:0]      in_y,
  input  logic [B-1:0]      in_z,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ITEM_W-1:0] out_item
);

  typedef struct packed {
    cmfuv_pkg::face_t face;
    logic             degen;
    logic [B:0]       dvs;   // 2 * major magnitude
    logic [B-1:0]     pu;    // u partial remainder
    logic [QB-1:0]    lu;    // u low dividend bits
    logic [B-1:0]     pv;
    logic [QB-1:0]    lv;
  } item_t;

  // Dividend = num * 2^16 + m; num is m +/- a, at most 2m.
  function automatic logic [B+QB-1:0] dividend(input logic [B-1:0] a,
                                               input logic [B-1:0] m,
                                               input logic         down);
    logic [B:0] num;
    num = down ? ({1'b0, m} - {1'b0, a}) : ({1'b0, m} + {1'b0, a});
    return {num, {cmfuv_pkg::FRAC_BITS{1'b0}}} + (B + QB)'(m);
  endfunction

  logic          valid;
  item_t         item;
  item_t         item_next;

  always_comb begin
    logic [B-1:0]    mx, my, mz, m, au, av;
    logic            nx, ny, nz, du, dv;
    logic [B+QB-1:0] dvd_u, dvd_v;

    nx = in_x[B-1];
    ny = in_y[B-1];
    nz = in_z[B-1];
    mx = nx ? (~in_x + 1'b1) : in_x;
    my = ny ? (~in_y + 1'b1) : in_y;
    mz = nz ? (~in_z + 1'b1) : in_z;

    // ties go to x, then y
    if (mx >= my && mx >= mz) begin
      item_next.face = nx ? cmfuv_pkg::FACE_NEG_X : cmfuv_pkg::FACE_POS_X;
      m  = mx;
      au = my;
      du = ny ^ ~nx;
      av = mz;
      dv = nz;
    end else if (my >= mz) begin
      item_next.face = ny ? cmfuv_pkg::FACE_NEG_Y : cmfuv_pkg::FACE_POS_Y;
      m  = my;
      au = mx;
      du = nx ^ ny;
      av = mz;
      dv = nz;
    end else begin
      item_next.face = nz ? cmfuv_pkg::FACE_NEG_Z : cmfuv_pkg::FACE_POS_Z;
      m  = mz;
      au = mx;
      du = nx;
      av = my;
      dv = ny ^ ~nz;
    end

    dvd_u = dividend(au, m, du);
    dvd_v = dividend(av, m, dv);

    item_next.degen = (m == '0);
    item_next.dvs   = {m, 1'b0};
    item_next.pu    = dvd_u[B+QB-1:QB];
    item_next.lu    = dvd_u[QB-1:0];
    item_next.pv    = dvd_v[B+QB-1:QB];
    item_next.lv    = dvd_v[QB-1:0];
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= item_next;
    end
  end

endmodule

@@ rtl/cmfuv_queue.sv @@
// Small register FIFO between the front end and the divider pipeline.
`timescale 1ns / 1ps
module cmfuv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CW'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

endmodule

@@ rtl/cmfuv_back.sv @@
// Back end: two pipelined restoring dividers, one quotient bit per stage.
`timescale 1ns / 1ps
module cmfuv_back #(
  parameter int COMPONENT_BITS = 16,
  localparam int B      = COMPONENT_BITS,
  localparam int QB     = cmfuv_pkg::QUOT_BITS,
  localparam int FB     = cmfuv_pkg::FRAC_BITS,
  localparam int ITEM_W = 4 + (B + 1) + 2 * (B + QB)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [ITEM_W-1:0] in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output cmfuv_pkg::face_t  out_face,
  output logic [FB-1:0]     out_u,
  output logic [FB-1:0]     out_v,
  output logic              out_degen
);

  typedef struct packed {
    cmfuv_pkg::face_t face;
    logic             degen;
    logic [B:0]       dvs;
    logic [B-1:0]     pu;
    logic [QB-1:0]    lu;
    logic [B-1:0]     pv;
    logic [QB-1:0]    lv;
  } item_t;

  typedef struct packed {
    cmfuv_pkg::face_t face;
    logic             degen;
    logic [B:0]       dvs;
    logic [B-1:0]     pu;
    logic [QB-1:0]    lu;
    logic [QB-1:0]    qu;
    logic [B-1:0]     pv;
    logic [QB-1:0]    lv;
    logic [QB-1:0]    qv;
  } stage_t;

  typedef struct packed {
    logic [B-1:0]  p;
    logic [QB-1:0] l;
    logic [QB-1:0] q;
  } div_t;

  // One restoring step: bring down the next dividend bit, subtract if it fits.
  function automatic div_t div_step(input div_t s, input logic [B:0] dvs);
    div_t       r;
    logic [B:0] t;
    t   = {s.p, s.l[QB-1]};
    r.l = {s.l[QB-2:0], 1'b0};
    if (t >= dvs) begin
      r.p = B'(t - dvs);
      r.q = {s.q[QB-2:0], 1'b1};
    end else begin
      r.p = t[B-1:0];
      r.q = {s.q[QB-2:0], 1'b0};
    end
    return r;
  endfunction

  function automatic stage_t stage_step(input stage_t s);
    stage_t r;
    div_t   du, dv;
    du      = div_step('{p: s.pu, l: s.lu, q: s.qu}, s.dvs);
    dv      = div_step('{p: s.pv, l: s.lv, q: s.qv}, s.dvs);
    r       = s;
    r.pu    = du.p;
    r.lu    = du.l;
    r.qu    = du.q;
    r.pv    = dv.p;
    r.lv    = dv.l;
    r.qv    = dv.q;
    return r;
  endfunction

  function automatic logic [FB-1:0] saturate(input logic [QB-1:0] q);
    return q[QB-1] ? cmfuv_pkg::COORD_MAX : q[FB-1:0];
  endfunction

  item_t         head;
  stage_t        head_stage;
  stage_t        stg [QB];
  logic [QB-1:0] stg_valid;
  logic          en;

  assign head = item_t'(in_item);

  always_comb begin
    head_stage.face  = head.face;
    head_stage.degen = head.degen;
    head_stage.dvs   = head.dvs;
    head_stage.pu    = head.pu;
    head_stage.lu    = head.lu;
    head_stage.qu    = '0;
    head_stage.pv    = head.pv;
    head_stage.lv    = head.lv;
    head_stage.qv    = '0;
  end

  // whole pipeline moves whenever the output register can take a word
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      stg_valid <= {stg_valid[QB-2:0], in_valid};
      out_valid <= stg_valid[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= stage_step(head_stage);
      for (int k = 1; k < QB; k++) begin
        stg[k] <= stage_step(stg[k-1]);
      end
      out_degen <= stg[QB-1].degen;
      if (stg[QB-1].degen) begin
        out_face <= cmfuv_pkg::FACE_POS_X;
        out_u    <= '0;
        out_v    <= '0;
      end else begin
        out_face <= stg[QB-1].face;
        out_u    <= saturate(stg[QB-1].qu);
        out_v    <= saturate(stg[QB-1].qv);
      end
    end
  end

endmodule
